// ===== rtl/keypoint_heading_validator_macros.svh =====
// Assertion macros for the keypoint heading validator.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef KEYPOINT_HEADING_VALIDATOR_MACROS_SVH
`define KEYPOINT_HEADING_VALIDATOR_MACROS_SVH

// same-cycle implication
`define KHV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KHV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/khv_pkg.sv =====
// Shared types, constants and tables of the keypoint heading validator.
// No dependencies.
package khv_pkg;

  localparam int ImageSize = 512;

  localparam logic [1:0] CfgMaxDist = 2'd0;
  localparam logic [1:0] CfgHeadMin = 2'd1;
  localparam logic [1:0] CfgYolkMin = 2'd2;

  localparam int CordicSteps = 16;

  localparam logic [17:0] AtanTab [CordicSteps] = '{
    18'd184320, 18'd108810, 18'd57492, 18'd29184, 18'd14649, 18'd7331, 18'd3667, 18'd1833,
    18'd917, 18'd458, 18'd229, 18'd115, 18'd57, 18'd29, 18'd14, 18'd7
  };

  localparam logic [14:0] HeadUp   = 15'd23040;
  localparam logic [14:0] HeadDown = 15'd11520;
  localparam logic [18:0] ZMax     = 19'd368640;

  typedef struct packed {
    logic signed [9:0] dx;
    logic signed [9:0] dy;
    logic [17:0]       dx2;
    logic [17:0]       dy2;
    logic [19:0]       d2;
    logic              ok;
  } prep_t;

  function automatic logic [8:0] khv_coord(logic [8:0] c);
    logic [12:0] lim;
    lim = 13'(ImageSize);
    if ({4'b0, c} >= lim) begin
      return 9'(ImageSize - 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/khv_prep.sv =====
// Front stages: coordinate clamp, differences, squares and all accept checks.
// Two register stages; depends on khv_pkg.
module khv_prep (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [8:0]          head_x_i,
  input  logic [8:0]          head_y_i,
  input  logic [8:0]          yolk_x_i,
  input  logic [8:0]          yolk_y_i,
  input  logic [15:0]         head_conf_i,
  input  logic [15:0]         yolk_conf_i,
  input  logic [9:0]          max_dist_i,
  input  logic [15:0]         head_min_i,
  input  logic [15:0]         yolk_min_i,
  output khv_pkg::prep_t      prep_o
);

  logic [8:0] hx, hy, yx, yy;
  logic signed [9:0] dx_d, dy_d;
  logic [8:0] adx, ady;
  logic signed [9:0] dx_q, dy_q;
  logic [17:0] dx2_q, dy2_q;
  logic zero_q, conf_q;
  logic [19:0] d2, mdsq;
  khv_pkg::prep_t prep_q;

  always_comb begin
    hx = khv_pkg::khv_coord(head_x_i);
    hy = khv_pkg::khv_coord(head_y_i);
    yx = khv_pkg::khv_coord(yolk_x_i);
    yy = khv_pkg::khv_coord(yolk_y_i);
    dx_d = $signed({1'b0, hx}) - $signed({1'b0, yx});
    dy_d = $signed({1'b0, hy}) - $signed({1'b0, yy});
    adx = dx_d[9] ? 9'(-dx_d) : dx_d[8:0];
    ady = dy_d[9] ? 9'(-dy_d) : dy_d[8:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      dx2_q  <= {9'b0, adx} * {9'b0, adx};
      dy2_q  <= {9'b0, ady} * {9'b0, ady};
      zero_q <= (hx == '0) && (hy == '0) && (yx == '0) && (yy == '0);
      conf_q <= (head_conf_i >= head_min_i) && (yolk_conf_i >= yolk_min_i);
    end
  end

  assign d2   = {2'b0, dx2_q} + {2'b0, dy2_q};
  assign mdsq = {10'b0, max_dist_i} * {10'b0, max_dist_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prep_q.dx  <= dx_q;
      prep_q.dy  <= dy_q;
      prep_q.dx2 <= dx2_q;
      prep_q.dy2 <= dy2_q;
      prep_q.d2  <= d2;
      prep_q.ok  <= (d2 <= mdsq) && (d2 >= 20'd9) && !zero_q && conf_q;
    end
  end

  assign prep_o = prep_q;

endmodule

// ===== rtl/khv_isqrt.sv =====
// Pipelined digit-by-digit integer square root, SPS result bits per stage.
// Gives floor root and remainder; no dependencies.
module khv_isqrt #(
  parameter int W   = 32,
  parameter int SPS = 4
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [W-1:0]     rad_i,
  output logic [W/2-1:0]   root_o,
  output logic [W/2:0]     rem_o
);

  localparam int HW  = W / 2;
  localparam int STG = HW / SPS;

  logic [HW:0]   rem_q  [STG];
  logic [HW-1:0] root_q [STG];
  logic [W-1:0]  rad_q  [STG];

  for (genvar s = 0; s < STG; s++) begin : g_stg
    logic [HW:0]   rem_in, rem_n;
    logic [HW-1:0] root_in, root_n;
    logic [W-1:0]  rad_in, rad_n;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
    end

    always_comb begin
      logic [HW+2:0] t, trial, diff;
      rem_n  = rem_in;
      root_n = root_in;
      rad_n  = rad_in;
      for (int k = 0; k < SPS; k++) begin
        t     = {rem_n, rad_n[W-1:W-2]};
        trial = {1'b0, root_n, 2'b01};
        diff  = t - trial;
        if (t >= trial) begin
          rem_n  = diff[HW:0];
          root_n = {root_n[HW-2:0], 1'b1};
        end else begin
          rem_n  = t[HW:0];
          root_n = {root_n[HW-2:0], 1'b0};
        end
        rad_n = {rad_n[W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_n;
        root_q[s] <= root_n;
        rad_q[s]  <= rad_n;
      end
    end
  end

  assign root_o = root_q[STG-1];
  assign rem_o  = rem_q[STG-1];

endmodule

// ===== rtl/khv_div.sv =====
// Pipelined restoring divider: floor(num * 2^30 / den), four quotient bits
// per stage over eight stages. No dependencies.
module khv_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [17:0] num_i,
  input  logic [19:0] den_i,
  output logic [31:0] quot_o
);

  localparam int SPS = 4;
  localparam int STG = 32 / SPS;

  logic [19:0] rem_q  [STG];
  logic [31:0] quot_q [STG];
  logic [31:0] feed_q [STG];
  logic [19:0] den_q  [STG];

  for (genvar s = 0; s < STG; s++) begin : g_stg
    logic [19:0] rem_in, rem_n, den_in;
    logic [31:0] quot_in, quot_n, feed_in, feed_n;

    if (s == 0) begin : g_first
      assign rem_in  = {4'b0, num_i[17:2]};
      assign quot_in = '0;
      assign feed_in = {num_i[1:0], 30'b0};
      assign den_in  = den_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quot_in = quot_q[s-1];
      assign feed_in = feed_q[s-1];
      assign den_in  = den_q[s-1];
    end

    always_comb begin
      logic [20:0] t, diff;
      rem_n  = rem_in;
      quot_n = quot_in;
      feed_n = feed_in;
      for (int k = 0; k < SPS; k++) begin
        t    = {rem_n, feed_n[31]};
        diff = t - {1'b0, den_in};
        if (t >= {1'b0, den_in}) begin
          rem_n  = diff[19:0];
          quot_n = {quot_n[30:0], 1'b1};
        end else begin
          rem_n  = t[19:0];
          quot_n = {quot_n[30:0], 1'b0};
        end
        feed_n = {feed_n[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_n;
        quot_q[s] <= quot_n;
        feed_q[s] <= feed_n;
        den_q[s]  <= den_in;
      end
    end
  end

  assign quot_o = quot_q[STG-1];

endmodule

// ===== rtl/khv_cordic.sv =====
// Vectoring CORDIC heading unit: four stages of four rotations, then clamp,
// rounding to 1/64 degree and quadrant fold. Depends on khv_pkg.
module khv_cordic (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic signed [9:0] dx_i,
  input  logic signed [9:0] dy_i,
  output logic [14:0]       heading_o
);

  localparam int SPS = 4;
  localparam int STG = khv_pkg::CordicSteps / SPS;

  typedef struct packed {
    logic dx_zero;
    logic dx_pos;
    logic a_pos;
    logic a_nneg;
  } quad_t;

  logic signed [27:0] x_q [STG];
  logic signed [27:0] y_q [STG];
  logic signed [20:0] z_q [STG];
  quad_t              qd_q [STG];
  logic [14:0]        head_q;

  logic [8:0] adx, ady;
  quad_t qd_in;

  always_comb begin
    adx = dx_i[9] ? 9'(-dx_i) : dx_i[8:0];
    ady = dy_i[9] ? 9'(-dy_i) : dy_i[8:0];
    qd_in.dx_zero = (dx_i == '0);
    qd_in.dx_pos  = !dx_i[9] && (dx_i != '0);
    qd_in.a_pos   = dy_i[9];
    qd_in.a_nneg  = dy_i[9] || (dy_i == '0);
  end

  for (genvar s = 0; s < STG; s++) begin : g_stg
    logic signed [27:0] x_in, y_in, x_n, y_n;
    logic signed [20:0] z_in, z_n;
    quad_t qd_s;

    if (s == 0) begin : g_first
      assign x_in = $signed({3'b0, ady, 16'b0});
      assign y_in = $signed({3'b0, adx, 16'b0});
      assign z_in = '0;
      assign qd_s = qd_in;
    end else begin : g_next
      assign x_in = x_q[s-1];
      assign y_in = y_q[s-1];
      assign z_in = z_q[s-1];
      assign qd_s = qd_q[s-1];
    end

    always_comb begin
      logic signed [27:0] xs, ys;
      logic signed [20:0] ang;
      x_n = x_in;
      y_n = y_in;
      z_n = z_in;
      for (int k = 0; k < SPS; k++) begin
        xs  = x_n >>> (s * SPS + k);
        ys  = y_n >>> (s * SPS + k);
        ang = $signed({3'b0, khv_pkg::AtanTab[4'(s * SPS + k)]});
        if (!y_n[27]) begin
          x_n = x_n + ys;
          y_n = y_n - xs;
          z_n = z_n + ang;
        end else begin
          x_n = x_n - ys;
          y_n = y_n + xs;
          z_n = z_n - ang;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s]  <= x_n;
        y_q[s]  <= y_n;
        z_q[s]  <= z_n;
        qd_q[s] <= qd_s;
      end
    end
  end

  logic [18:0] zc;
  logic [19:0] zr;
  logic [14:0] phi;
  logic [14:0] head_d;
  quad_t qd_l;

  always_comb begin
    qd_l = qd_q[STG-1];
    if (z_q[STG-1][20]) begin
      zc = '0;
    end else if (z_q[STG-1][19:0] > {1'b0, khv_pkg::ZMax}) begin
      zc = khv_pkg::ZMax;
    end else begin
      zc = z_q[STG-1][18:0];
    end
    zr  = {1'b0, zc} + 20'd32;
    phi = {2'b0, zr[18:6]};
    if (qd_l.dx_zero) begin
      head_d = qd_l.a_pos ? khv_pkg::HeadUp : khv_pkg::HeadDown;
    end else if (qd_l.dx_pos) begin
      head_d = qd_l.a_nneg ? phi : khv_pkg::HeadDown - phi;
    end else begin
      head_d = qd_l.a_nneg ? khv_pkg::HeadUp - phi : khv_pkg::HeadDown + phi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      head_q <= head_d;
    end
  end

  assign heading_o = head_q;

endmodule

// ===== rtl/keypoint_heading_validator.sv =====
// Top level of the keypoint heading validator: config registers, pipeline
// control, unit alignment and output stage. Uses khv_pkg, khv_prep,
// khv_div, khv_isqrt, khv_cordic and the assertion macro header.
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: keypoints, confidences
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: heading, dist, dir; tuser
// cfg       in   cfg_we_i                       cfg_idx_i, cfg_data_i
//
// One item per cycle while the output is not held; 15 register stages.
// Depth is set by the 32-step divider and 16-step root on the direction path.
// Reset clears the valid bits and loads the register defaults.
// A held output freezes every stage; bubbles are not squeezed out.
`include "keypoint_heading_validator_macros.svh"

module keypoint_heading_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // head_x[8:0] head_y[17:9] yolk_x[26:18] yolk_y[35:27]
  // head_conf[51:36] yolk_conf[67:52], zero fill
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // heading[14:0] distance[30:15] dir_x[46:31] dir_y[62:47], zero fill
  output logic [63:0] m_axis_tdata,
  // detected[0]
  output logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int Depth = 15;

  logic [9:0]  max_dist_q;
  logic [15:0] head_min_q, yolk_min_q;
  logic [Depth-1:0] vld_q;
  logic en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= 10'd29;
      head_min_q <= '0;
      yolk_min_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        khv_pkg::CfgMaxDist: max_dist_q <= cfg_data_i[9:0];
        khv_pkg::CfgHeadMin: head_min_q <= cfg_data_i;
        khv_pkg::CfgYolkMin: yolk_min_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en            = !vld_q[Depth-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end

  khv_pkg::prep_t prep;

  khv_prep u_prep (
    .clk_i       (clk_i),
    .en_i        (en),
    .head_x_i    (s_axis_tdata[8:0]),
    .head_y_i    (s_axis_tdata[17:9]),
    .yolk_x_i    (s_axis_tdata[26:18]),
    .yolk_y_i    (s_axis_tdata[35:27]),
    .head_conf_i (s_axis_tdata[51:36]),
    .yolk_conf_i (s_axis_tdata[67:52]),
    .max_dist_i  (max_dist_q),
    .head_min_i  (head_min_q),
    .yolk_min_i  (yolk_min_q),
    .prep_o      (prep)
  );

  // distance: sqrt(d2 * 4096)
  logic [15:0] droot;
  logic [16:0] drem;

  khv_isqrt #(.W(32), .SPS(4)) u_dsqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({prep.d2, 12'b0}),
    .root_o (droot),
    .rem_o  (drem)
  );

  // direction: sqrt(m^2 * 2^30 / d2) per component
  logic [31:0] qx, qy;
  logic [15:0] rx, ry;
  logic [16:0] rx_rem, ry_rem;

  khv_div u_divx (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (prep.dx2),
    .den_i  (prep.d2),
    .quot_o (qx)
  );

  khv_div u_divy (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (prep.dy2),
    .den_i  (prep.d2),
    .quot_o (qy)
  );

  khv_isqrt #(.W(32), .SPS(4)) u_xsqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (qx),
    .root_o (rx),
    .rem_o  (rx_rem)
  );

  khv_isqrt #(.W(32), .SPS(4)) u_ysqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (qy),
    .root_o (ry),
    .rem_o  (ry_rem)
  );

  logic [14:0] heading;

  khv_cordic u_cordic (
    .clk_i     (clk_i),
    .en_i      (en),
    .dx_i      (prep.dx),
    .dy_i      (prep.dy),
    .heading_o (heading)
  );

  // alignment delays to the direction path
  logic [32:0] dist_dl_q [8];
  logic [14:0] head_dl_q [7];
  logic [2:0]  side_dl_q [12];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_dl_q[0] <= {drem, droot};
      for (int i = 1; i < 8; i++) begin
        dist_dl_q[i] <= dist_dl_q[i-1];
      end
      head_dl_q[0] <= heading;
      for (int i = 1; i < 7; i++) begin
        head_dl_q[i] <= head_dl_q[i-1];
      end
      side_dl_q[0] <= {prep.dy[9], prep.dx[9], prep.ok};
      for (int i = 1; i < 12; i++) begin
        side_dl_q[i] <= side_dl_q[i-1];
      end
    end
  end

  logic [15:0] root_a;
  logic [16:0] rem_a, dist_s, mx_s, my_s;
  logic [15:0] dx_d, dy_d;
  logic        ok_a;
  logic [62:0] data_d;
  logic [63:0] data_q;
  logic        det_q;

  always_comb begin
    root_a = dist_dl_q[7][15:0];
    rem_a  = dist_dl_q[7][32:16];
    ok_a   = side_dl_q[11][0];
    dist_s = {1'b0, root_a} + {16'b0, (rem_a > {1'b0, root_a})};
    mx_s   = {1'b0, rx} + 17'd1;
    my_s   = {1'b0, ry} + 17'd1;
    dx_d   = side_dl_q[11][1] ? 16'(-mx_s[16:1]) : mx_s[16:1];
    dy_d   = side_dl_q[11][2] ? 16'(-my_s[16:1]) : my_s[16:1];
    data_d = {dy_d, dx_d, dist_s[15:0], head_dl_q[6]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= ok_a ? {1'b0, data_d} : '0;
      det_q  <= ok_a;
    end
  end

  assign m_axis_tvalid = vld_q[Depth-1];
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = det_q;

  `KHV_ASSERT_IMPL(a_reject_zero, m_axis_tvalid && !m_axis_tuser,
                   m_axis_tdata == 64'd0, "rejected item carries data")
  `KHV_ASSERT_IMPL(a_head_range, m_axis_tvalid && m_axis_tuser,
                   (m_axis_tdata[14:0] != 15'd0) &&
                   (m_axis_tdata[14:0] <= khv_pkg::HeadUp), "heading out of range")
  `KHV_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
                   "stalled item changed")

endmodule
